>>> design/esc_telemetry_frame_decoder_defines.svh
// Assertion macros for the telemetry frame decoder checker.
// Expects clk and rst_n in the scope of each use.
`ifndef ESC_TELEMETRY_FRAME_DECODER_DEFINES_SVH
`define ESC_TELEMETRY_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication.
`define ETFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ETFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/etfd_pkg.sv
// Package for the telemetry frame decoder: field widths, frame constants,
// unit status type and the scale-by-100 helper. No dependencies.
package etfd_pkg;

    localparam int FRAME_BYTES = 10;
    localparam int CRC_BYTES   = FRAME_BYTES - 1;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int POLE_W      = 7;
    localparam int RATE_W      = 23;
    localparam int HELD_W      = 4;
    localparam int CRC_BITS    = CRC_BYTES * BYTE_W;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [BYTE_W-1:0] CRC_POLY         = 8'h07;
    localparam logic [POLE_W-1:0] POLE_COUNT_RESET = 7'd14;

    // Register index codes (paddr[2])
    localparam logic REG_POLE_COUNT = 1'b0;

    typedef struct packed {
        logic busy;
        logic done;
    } etfd_unit_status_t;

    // 100 * v as 64v + 32v + 4v
    function automatic logic [RATE_W-1:0] scale_by_100(input logic [WORD_W-1:0] v);
        logic [RATE_W-1:0] x;
        x = {{(RATE_W-WORD_W){1'b0}}, v};
        return (x << 6) + (x << 5) + (x << 2);
    endfunction

endpackage

>>> design/etfd_byte_if.sv
// Receive byte channel: valid/ready request carrying one telemetry byte.
// Depends on etfd_pkg.
interface etfd_byte_if
    import etfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> design/etfd_telem_if.sv
// Decoded telemetry channel: valid/ready request carrying one frame result.
// Depends on etfd_pkg.
interface etfd_telem_if
    import etfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] temperature;
    logic [WORD_W-1:0] voltage_centi;
    logic [WORD_W-1:0] current_centi;
    logic [WORD_W-1:0] consumption;
    logic [RATE_W-1:0] erpm;
    logic [RATE_W-1:0] rpm;

    modport source (output valid, output temperature, output voltage_centi,
                    output current_centi, output consumption, output erpm,
                    output rpm, input ready);
    modport sink   (input valid, input temperature, input voltage_centi,
                    input current_centi, input consumption, input erpm,
                    input rpm, output ready);
endinterface

>>> design/etfd_crc_serial.sv
// Bit-serial CRC-8 (poly 0x07, init 0) over the nine oldest window bytes,
// one bit per cycle, MSB of the oldest byte first. Depends on etfd_pkg.
module etfd_crc_serial
    import etfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CRC_BITS-1:0] data,
    output etfd_unit_status_t   status,
    output logic [BYTE_W-1:0]   crc
);

    localparam int CNT_W = $clog2(CRC_BITS + 1);

    logic [CRC_BITS-1:0] shift_reg, shift_next;
    logic [BYTE_W-1:0]   crc_reg, crc_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic                fb;

    always_comb
    begin
        shift_next = shift_reg;
        crc_next   = crc_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        fb         = crc_reg[BYTE_W-1] ^ shift_reg[CRC_BITS-1];
        if (start)
        begin
            shift_next = data;
            crc_next   = '0;
            cnt_next   = CNT_W'(CRC_BITS);
        end
        else if (cnt_reg != '0)
        begin
            shift_next = {shift_reg[CRC_BITS-2:0], 1'b0};
            crc_next   = {crc_reg[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
            cnt_next   = cnt_reg - 1'b1;
            done_next  = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            crc_reg  <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            crc_reg  <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign crc         = crc_reg;

endmodule

>>> design/etfd_div_serial.sv
// Restoring bit-serial divider: 16-bit raw eRPM by 7-bit pole count,
// one quotient bit per cycle; a zero divisor counts as one. Depends on etfd_pkg.
module etfd_div_serial
    import etfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [POLE_W-1:0] divisor,
    output etfd_unit_status_t status,
    output logic [WORD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [WORD_W-1:0] q_reg, q_next;
    logic [POLE_W-1:0] rem_reg, rem_next;
    logic [POLE_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [POLE_W:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[WORD_W-1]};
        if (start)
        begin
            q_next   = dividend;
            rem_next = '0;
            d_next   = (divisor == '0) ? POLE_W'(1) : divisor;
            cnt_next = CNT_W'(WORD_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = POLE_W'(trial - {1'b0, d_reg});
                q_next   = {q_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[POLE_W-1:0];
                q_next   = {q_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign quotient    = q_reg;

endmodule

>>> design/esc_telemetry_frame_decoder.sv
// Telemetry frame decoder top level: byte window, frame control, result
// register and APB register. Depends on etfd_pkg, the channel interfaces,
// etfd_crc_serial and etfd_div_serial.
//
// Bytes are taken one per request on rx. Until ten bytes have arrived since
// reset or the last good frame, rx stays ready and a byte only enters the
// window. With a full window every byte starts a bit-serial CRC over the
// nine oldest bytes, and rx is low while it runs; on a match the serial
// divider for RPM runs next and rx stays low until the result is loaded.
// A result waits in the output register while the next byte is taken; a
// further good frame holds in its last step until that result is taken.
// pole_count sits at byte address 0.
module esc_telemetry_frame_decoder
    import etfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    etfd_byte_if.sink             rx,
    etfd_telem_if.source          telem,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_DIV,
        ST_HOLD
    } state_t;

    localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(FRAME_BYTES);

    state_t            state_reg, state_next;
    logic [BYTE_W-1:0] window_reg [FRAME_BYTES];
    logic [BYTE_W-1:0] window_next [FRAME_BYTES];
    logic [HELD_W-1:0] held_reg, held_next, held_inc;
    logic              crc_start_reg, crc_start_next;
    logic              div_start_reg, div_start_next;
    logic              out_valid_reg, out_valid_next;
    logic              load;
    logic [POLE_W-1:0] pole_count_reg;

    logic [BYTE_W-1:0] temp_reg;
    logic [WORD_W-1:0] volt_reg;
    logic [WORD_W-1:0] curr_reg;
    logic [WORD_W-1:0] cons_reg;
    logic [RATE_W-1:0] erpm_reg;
    logic [RATE_W-1:0] rpm_reg;

    logic                rx_fire;
    logic                cfg_write;
    logic [CRC_BITS-1:0] crc_data;
    logic [BYTE_W-1:0]   crc_value;
    logic [WORD_W-1:0]   raw_erpm;
    logic [WORD_W-1:0]   quotient;
    etfd_unit_status_t   crc_stat;
    etfd_unit_status_t   div_stat;

    assign rx_fire  = rx.valid && rx.ready;
    assign rx.ready = (state_reg == ST_IDLE);
    assign raw_erpm = {window_reg[7], window_reg[8]};

    always_comb
    begin
        for (int i = 0; i < CRC_BYTES; i++)
        begin
            crc_data[CRC_BITS-1-i*BYTE_W -: BYTE_W] = window_reg[i];
        end
    end

    etfd_crc_serial u_crc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (crc_start_reg),
        .data   (crc_data),
        .status (crc_stat),
        .crc    (crc_value)
    );

    etfd_div_serial u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (raw_erpm),
        .divisor  (pole_count_reg),
        .status   (div_stat),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        held_next      = held_reg;
        crc_start_next = 1'b0;
        div_start_next = 1'b0;
        load           = 1'b0;
        held_inc       = (held_reg == HELD_FULL) ? HELD_FULL : held_reg + 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx_fire)
                begin
                    for (int i = 0; i < FRAME_BYTES - 1; i++)
                    begin
                        window_next[i] = window_reg[i+1];
                    end
                    window_next[FRAME_BYTES-1] = rx.rx_byte;
                    held_next = held_inc;
                    if (held_inc == HELD_FULL)
                    begin
                        crc_start_next = 1'b1;
                        state_next     = ST_CRC;
                    end
                end
            end
            ST_CRC:
            begin
                if (crc_stat.done && !crc_stat.busy)
                begin
                    if (crc_value == window_reg[FRAME_BYTES-1])
                    begin
                        held_next      = '0;
                        div_start_next = 1'b1;
                        state_next     = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || telem.ready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && telem.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            crc_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            temp_reg      <= '0;
            volt_reg      <= '0;
            curr_reg      <= '0;
            cons_reg      <= '0;
            erpm_reg      <= '0;
            rpm_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            crc_start_reg <= crc_start_next;
            div_start_reg <= div_start_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                temp_reg <= window_reg[0];
                volt_reg <= {window_reg[1], window_reg[2]};
                curr_reg <= {window_reg[3], window_reg[4]};
                cons_reg <= {window_reg[5], window_reg[6]};
                erpm_reg <= scale_by_100(raw_erpm);
                rpm_reg  <= scale_by_100(quotient);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_count_reg <= POLE_COUNT_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_POLE_COUNT))
        begin
            pole_count_reg <= pwdata[POLE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POLE_COUNT)
                  ? {{(APB_DATA_W-POLE_W){1'b0}}, pole_count_reg}
                  : '0;

    assign telem.valid         = out_valid_reg;
    assign telem.temperature   = temp_reg;
    assign telem.voltage_centi = volt_reg;
    assign telem.current_centi = curr_reg;
    assign telem.consumption   = cons_reg;
    assign telem.erpm          = erpm_reg;
    assign telem.rpm           = rpm_reg;

endmodule

>>> design/etfd_checker.sv
// Port-level checker for the telemetry frame decoder, bound to the top level.
// Depends on etfd_pkg and esc_telemetry_frame_decoder_defines.svh.
`include "esc_telemetry_frame_decoder_defines.svh"

module etfd_checker
    import etfd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [BYTE_W-1:0]     temperature,
    input logic [WORD_W-1:0]     voltage_centi,
    input logic [RATE_W-1:0]     erpm,
    input logic [RATE_W-1:0]     rpm,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic                  pready,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata
);

    `ETFD_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(temperature) && $stable(voltage_centi) && $stable(rpm),
        "stalled result changed or dropped")

    `ETFD_ASSERT_IMP(a_result_after_busy, $rose(out_valid), !$past(in_ready),
        "result appeared without a busy phase")

    `ETFD_ASSERT_IMP(a_rpm_bound, out_valid, rpm <= erpm,
        "rpm exceeds erpm")

    `ETFD_ASSERT_IMP(a_pole_readback,
        (psel && penable && pwrite && pready && (paddr[2] == REG_POLE_COUNT))
            ##1 (paddr[2] == REG_POLE_COUNT),
        (prdata[POLE_W-1:0] == $past(pwdata[POLE_W-1:0]))
            && (prdata[APB_DATA_W-1:POLE_W] == '0),
        "pole_count readback mismatch")

endmodule

bind esc_telemetry_frame_decoder etfd_checker u_etfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (rx.ready),
    .out_valid     (telem.valid),
    .out_ready     (telem.ready),
    .temperature   (telem.temperature),
    .voltage_centi (telem.voltage_centi),
    .erpm          (telem.erpm),
    .rpm           (telem.rpm),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);
